### design/txfmt_pkg.sv
// Shared types, register indexes and channel expansion tables for the
// texel format converter. No dependencies; used by the top level and its checker.
package txfmt_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 9;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_TEXEL_FORMAT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RAW_LOAD     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TINT_RED     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TINT_GREEN   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_TINT_BLUE    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_TINT_ALPHA   = 3'd5;

	localparam logic [8:0] TINT_UNITY = 9'd256;

	// Source texel layouts
	typedef enum logic [2:0] {
		FMT_RGBA32  = 3'd0,
		FMT_RGBA16  = 3'd1,
		FMT_IA16    = 3'd2,
		FMT_IA8     = 3'd3,
		FMT_IA4     = 3'd4,
		FMT_I8      = 3'd5,
		FMT_I4      = 3'd6,
		FMT_PALETTE = 3'd7
	} fmt_e;

	typedef struct packed {
		logic [7:0] src_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last_pixel;
		logic       unsupported;
	} out_item_t;

	// Untinted pixel with its end-of-texture mark
	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		logic       last;
	} pixel_t;

	// Source bytes making up one pixel
	function automatic logic [2:0] bytes_per_pixel(input fmt_e fmt);
		unique case (fmt)
			FMT_RGBA32:                 return 3'd4;
			FMT_RGBA16, FMT_IA16:       return 3'd2;
			FMT_IA8, FMT_IA4, FMT_I8,
			FMT_I4, FMT_PALETTE:        return 3'd1;
			default:                    return 3'd1;
		endcase
	endfunction

	// floor(c * 255 / 31)
	function automatic logic [7:0] expand5(input logic [4:0] c);
		unique case (c)
			5'd0:  return 8'd0;    5'd1:  return 8'd8;
			5'd2:  return 8'd16;   5'd3:  return 8'd24;
			5'd4:  return 8'd32;   5'd5:  return 8'd41;
			5'd6:  return 8'd49;   5'd7:  return 8'd57;
			5'd8:  return 8'd65;   5'd9:  return 8'd74;
			5'd10: return 8'd82;   5'd11: return 8'd90;
			5'd12: return 8'd98;   5'd13: return 8'd106;
			5'd14: return 8'd115;  5'd15: return 8'd123;
			5'd16: return 8'd131;  5'd17: return 8'd139;
			5'd18: return 8'd148;  5'd19: return 8'd156;
			5'd20: return 8'd164;  5'd21: return 8'd172;
			5'd22: return 8'd180;  5'd23: return 8'd189;
			5'd24: return 8'd197;  5'd25: return 8'd205;
			5'd26: return 8'd213;  5'd27: return 8'd222;
			5'd28: return 8'd230;  5'd29: return 8'd238;
			5'd30: return 8'd246;  5'd31: return 8'd255;
			default: return 8'd0;
		endcase
	endfunction

	// floor(c * 255 / 7)
	function automatic logic [7:0] expand3(input logic [2:0] c);
		unique case (c)
			3'd0: return 8'd0;
			3'd1: return 8'd36;
			3'd2: return 8'd72;
			3'd3: return 8'd109;
			3'd4: return 8'd145;
			3'd5: return 8'd182;
			3'd6: return 8'd218;
			3'd7: return 8'd255;
			default: return 8'd0;
		endcase
	endfunction

	// min(255, (c * f) >> 8)
	function automatic logic [7:0] apply_tint(input logic [7:0] c, input logic [8:0] f);
		logic [16:0] p;
		p = 17'(c) * 17'(f);
		return p[16] ? 8'hFF : p[15:8];
	endfunction

endpackage

### design/texel_format_to_rgba8888.sv
// Texel format converter: packed texture bytes in, tinted RGBA8888 pixels out.
// Depends on txfmt_pkg for payload types, format codes and expansion tables.
//
// Usage:
//   in_*   : one source byte per transfer, last_byte marks the texture end.
//   out_*  : one RGBA8888 pixel per transfer, with last_pixel and unsupported.
//   cfg_*  : register writes (format, raw copy, four Q1.8 tints); always ready.
//            Write only while no pixel is in flight. Writing the format or raw
//            register drops any partly assembled pixel.
// Latency: a byte that completes a pixel shows that pixel on out_valid in the
//   next cycle. Bytes of a multi-byte pixel are held and give no output.
// Throughput: one byte per cycle for 8/16/32-bit layouts while out_ready is
//   high; the 4-bit layouts give two pixels per byte, and the second pixel
//   waits in a pending register that holds in_ready low until it moves on.
// Reset: format rgba32, raw copy off, tints 256, no bytes held, output empty.
// Stall: while out_ready is low the pixel holds and in_ready drops, so no
//   byte is taken until the output register frees up.
module texel_format_to_rgba8888 (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  txfmt_pkg::in_item_t                  in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output txfmt_pkg::out_item_t                 out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [txfmt_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [txfmt_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import txfmt_pkg::*;

	// Configuration registers
	fmt_e       fmt_q;
	logic       raw_q;
	logic [8:0] tint_r_q, tint_g_q, tint_b_q, tint_a_q;

	// Pixel assembly state
	logic [23:0] held_q;
	logic [1:0]  phase_q;

	// Output register and second pixel of a 4-bit byte
	logic      res_valid_q;
	out_item_t res_q;
	logic      pend_valid_q;
	pixel_t    pend_q;

	logic      in_xfer, out_xfer, cfg_xfer, cfg_clear;
	logic [7:0]  sb;
	logic [2:0]  need;
	logic        hold_byte, unsup, two_px, emit;
	logic [31:0] px;
	logic [3:0]  hi, lo;
	pixel_t      pix0, pix1, tin;
	out_item_t   res_d;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid & cfg_ready;
	assign cfg_clear = cfg_xfer &&
		(cfg_index == REG_TEXEL_FORMAT || cfg_index == REG_RAW_LOAD);

	assign in_ready  = !pend_valid_q && (!res_valid_q || out_ready);
	assign in_xfer   = in_valid & in_ready;
	assign out_valid = res_valid_q;
	assign out_data  = res_q;
	assign out_xfer  = out_valid & out_ready;

	// Byte assembly
	assign sb        = in_data.src_byte;
	assign need      = raw_q ? 3'd4 : bytes_per_pixel(fmt_q);
	assign unsup     = (fmt_q == FMT_PALETTE);
	assign hold_byte = !unsup && !in_data.last_byte && ({1'b0, phase_q} + 3'd1 < need);
	assign px        = {8'h00, held_q} | ({24'h0, sb} << {phase_q, 3'b000});
	assign hi        = sb[7:4];
	assign lo        = sb[3:0];
	assign emit      = in_xfer && !hold_byte;

	// Layout decode into up to two untinted pixels
	always_comb begin
		pix0   = '0;
		pix1   = '0;
		two_px = 1'b0;
		if (unsup) begin
			pix0.last = in_data.last_byte;
		end else if (raw_q) begin
			pix0 = '{r: px[7:0], g: px[15:8], b: px[23:16], a: px[31:24],
				last: in_data.last_byte};
		end else begin
			unique case (fmt_q)
				FMT_RGBA32, FMT_PALETTE: begin
					pix0 = '{r: px[7:0], g: px[15:8], b: px[23:16], a: px[31:24],
						last: in_data.last_byte};
				end
				FMT_RGBA16: begin
					pix0 = '{r: expand5(px[7:3]), g: expand5({px[2:0], px[15:14]}),
						b: expand5(px[13:9]), a: {8{px[8]}}, last: in_data.last_byte};
				end
				FMT_IA16: begin
					pix0 = '{r: px[7:0], g: px[7:0], b: px[7:0], a: px[15:8],
						last: in_data.last_byte};
				end
				FMT_IA8: begin
					pix0 = '{r: {hi, hi}, g: {hi, hi}, b: {hi, hi}, a: {lo, lo},
						last: in_data.last_byte};
				end
				FMT_IA4: begin
					two_px = 1'b1;
					pix0 = '{r: expand3(hi[3:1]), g: expand3(hi[3:1]), b: expand3(hi[3:1]),
						a: {8{hi[0]}}, last: 1'b0};
					pix1 = '{r: expand3(lo[3:1]), g: expand3(lo[3:1]), b: expand3(lo[3:1]),
						a: {8{lo[0]}}, last: in_data.last_byte};
				end
				FMT_I8: begin
					pix0 = '{r: sb, g: sb, b: sb, a: sb, last: in_data.last_byte};
				end
				FMT_I4: begin
					two_px = 1'b1;
					pix0 = '{r: {hi, hi}, g: {hi, hi}, b: {hi, hi}, a: {hi, hi}, last: 1'b0};
					pix1 = '{r: {lo, lo}, g: {lo, lo}, b: {lo, lo}, a: {lo, lo},
						last: in_data.last_byte};
				end
				default: begin
					pix0 = '0;
				end
			endcase
		end
	end

	// Tint stage, shared by fresh pixels and the pending second pixel
	always_comb begin
		tin = pend_valid_q ? pend_q : pix0;
		res_d.red         = apply_tint(tin.r, tint_r_q);
		res_d.green       = apply_tint(tin.g, tint_g_q);
		res_d.blue        = apply_tint(tin.b, tint_b_q);
		res_d.alpha       = apply_tint(tin.a, tint_a_q);
		res_d.last_pixel  = tin.last;
		res_d.unsupported = !pend_valid_q && unsup;
	end

	// Configuration registers and assembly state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_RGBA32;
			raw_q    <= 1'b0;
			tint_r_q <= TINT_UNITY;
			tint_g_q <= TINT_UNITY;
			tint_b_q <= TINT_UNITY;
			tint_a_q <= TINT_UNITY;
			held_q   <= '0;
			phase_q  <= '0;
		end else begin
			if (cfg_xfer) begin
				unique case (cfg_index)
					REG_TEXEL_FORMAT: fmt_q    <= fmt_e'(cfg_data[2:0]);
					REG_RAW_LOAD:     raw_q    <= cfg_data[0];
					REG_TINT_RED:     tint_r_q <= cfg_data;
					REG_TINT_GREEN:   tint_g_q <= cfg_data;
					REG_TINT_BLUE:    tint_b_q <= cfg_data;
					REG_TINT_ALPHA:   tint_a_q <= cfg_data;
					default: ;
				endcase
			end
			if (cfg_clear) begin
				held_q  <= '0;
				phase_q <= '0;
			end else if (in_xfer) begin
				if (hold_byte) begin
					held_q  <= px[23:0];
					phase_q <= phase_q + 2'd1;
				end else begin
					held_q  <= '0;
					phase_q <= '0;
				end
			end
		end
	end

	// Output register and pending pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (pend_valid_q && out_xfer) begin
				pend_valid_q <= 1'b0;
			end else if (emit) begin
				res_valid_q  <= 1'b1;
				pend_valid_q <= two_px;
			end else if (out_xfer) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers, no reset
	always_ff @(posedge clk) begin
		if ((pend_valid_q && out_xfer) || emit) begin
			res_q <= res_d;
		end
		if (emit && two_px) begin
			pend_q <= pix1;
		end
	end

endmodule

### design/txfmt_checker.sv
// Port-level checks for texel_format_to_rgba8888, attached by bind.
// Depends on txfmt_pkg for the payload types.
module txfmt_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input txfmt_pkg::out_item_t out_data,
	input logic                 cfg_ready
);
	import txfmt_pkg::*;

	// A stalled pixel stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output pixel changed while stalled");

	// A stalled output register blocks new bytes
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("byte taken while output stalled");

	// Unsupported pixels carry zero channels
	a_unsup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.unsupported |->
		out_data.red == 8'd0 && out_data.green == 8'd0 &&
		out_data.blue == 8'd0 && out_data.alpha == 8'd0)
		else $error("unsupported pixel with nonzero channels");

	// Register writes are never stalled
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind texel_format_to_rgba8888 txfmt_checker u_txfmt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_ready (cfg_ready)
);
